[design/psd_pkg.sv]
// shared constants, types and helpers for the point to segment distance block
// no dependencies
package psd_pkg;

  // coordinate width and widths derived from it
  localparam int CW   = 24;        // coordinate field width
  localparam int DW   = CW + 1;    // coordinate difference width
  localparam int MW   = DW;        // magnitude width of a difference
  localparam int L2W  = 2 * MW;    // squared length and dot product magnitude
  localparam int NUMW = 3 * MW;    // divider numerator
  localparam int QW   = MW;        // divider quotient bits, one per stage
  localparam int SSW  = 2 * MW;    // squared distance
  localparam int SRW  = MW;        // square root bits, one per stage
  localparam int REMW = SRW + 2;   // square root remainder
  localparam int OW   = CW + 1;    // distance field width
  localparam int FLAT = 5;         // front pipeline stages
  localparam int BLAT = QW + SRW + 6; // back pipeline stages

  // region codes
  localparam logic [1:0] REGION_START  = 2'd0;
  localparam logic [1:0] REGION_END    = 2'd1;
  localparam logic [1:0] REGION_INSIDE = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]     region;
    logic [CW-1:0]  a_x;
    logic [CW-1:0]  a_y;
    logic [CW-1:0]  b_x;
    logic [CW-1:0]  b_y;
    logic [CW-1:0]  c_x;
    logic [CW-1:0]  c_y;
    logic [DW-1:0]  d_x;
    logic [DW-1:0]  d_y;
    logic [L2W-1:0] dot;   // zero unless inside
    logic [L2W-1:0] len2;  // one unless inside
  } job_t;

  function automatic logic [DW-1:0] sx(input logic [CW-1:0] v);
    sx = {v[CW-1], v};
  endfunction

  function automatic logic [MW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

[design/psd_queue.sv]
// two entry queue of classified items between front and back
// depends on psd_pkg
module psd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  psd_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output psd_pkg::job_t job_out,
  output logic          empty
);

  psd_pkg::job_t ent_r [2];
  logic          wr_r;
  logic          rd_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = ent_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= !wr_r;
      end
      if (do_pop) begin
        rd_r <= !rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= job_in;
    end
  end

endmodule

[design/psd_front.sv]
// front pipeline: takes items, forms differences, squared length and dot product,
// and classifies the region; depends on psd_pkg
module psd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic signed [psd_pkg::CW-1:0]  in_seg_start_x,
  input  logic signed [psd_pkg::CW-1:0]  in_seg_start_y,
  input  logic signed [psd_pkg::CW-1:0]  in_seg_end_x,
  input  logic signed [psd_pkg::CW-1:0]  in_seg_end_y,
  input  logic signed [psd_pkg::CW-1:0]  in_query_x,
  input  logic signed [psd_pkg::CW-1:0]  in_query_y,
  input  logic                           q_full,
  output logic                           job_vld,
  output psd_pkg::job_t                  job
);

  typedef struct packed {
    logic [psd_pkg::CW-1:0] a_x;
    logic [psd_pkg::CW-1:0] a_y;
    logic [psd_pkg::CW-1:0] b_x;
    logic [psd_pkg::CW-1:0] b_y;
    logic [psd_pkg::CW-1:0] c_x;
    logic [psd_pkg::CW-1:0] c_y;
  } pts_t;

  logic [psd_pkg::FLAT-1:0] vld_r;
  logic                     en;

  pts_t p1_r, p2_r, p3_r, p4_r;
  logic signed [psd_pkg::DW-1:0]   dx_r, dy_r, ex_r, ey_r;
  logic signed [2*psd_pkg::DW-1:0] dxx_r, dyy_r, exdx_r, eydy_r;
  logic signed [2*psd_pkg::DW-1:0] dx3_r, dy3_r;
  logic signed [psd_pkg::DW-1:0]   dx4_r, dy4_r;
  logic [psd_pkg::L2W-1:0]         len2_r;
  logic signed [2*psd_pkg::DW:0]   dot_r;
  psd_pkg::job_t                   job_r;
  psd_pkg::job_t                   job_nxt;

  logic [psd_pkg::L2W-1:0] dot_mag;

  assign en      = !(vld_r[psd_pkg::FLAT-1] && q_full);
  assign full    = !en;
  assign job_vld = vld_r[psd_pkg::FLAT-1];
  assign job     = job_r;
  assign dot_mag = dot_r[psd_pkg::L2W-1:0];

  // region decision
  always_comb begin
    job_nxt.a_x  = p4_r.a_x;
    job_nxt.a_y  = p4_r.a_y;
    job_nxt.b_x  = p4_r.b_x;
    job_nxt.b_y  = p4_r.b_y;
    job_nxt.c_x  = p4_r.c_x;
    job_nxt.c_y  = p4_r.c_y;
    job_nxt.d_x  = dx4_r;
    job_nxt.d_y  = dy4_r;
    job_nxt.dot  = '0;
    job_nxt.len2 = {{(psd_pkg::L2W-1){1'b0}}, 1'b1};
    if (len2_r == '0 || dot_r[2*psd_pkg::DW]) begin
      job_nxt.region = psd_pkg::REGION_START;
    end else if (dot_mag > len2_r) begin
      job_nxt.region = psd_pkg::REGION_END;
    end else begin
      job_nxt.region = psd_pkg::REGION_INSIDE;
      job_nxt.dot    = dot_mag;
      job_nxt.len2   = len2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[psd_pkg::FLAT-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // input register
      p1_r <= {in_seg_start_x, in_seg_start_y, in_seg_end_x, in_seg_end_y,
               in_query_x, in_query_y};
      // differences
      p2_r <= p1_r;
      dx_r <= psd_pkg::sx(p1_r.b_x) - psd_pkg::sx(p1_r.a_x);
      dy_r <= psd_pkg::sx(p1_r.b_y) - psd_pkg::sx(p1_r.a_y);
      ex_r <= psd_pkg::sx(p1_r.c_x) - psd_pkg::sx(p1_r.a_x);
      ey_r <= psd_pkg::sx(p1_r.c_y) - psd_pkg::sx(p1_r.a_y);
      // products
      p3_r   <= p2_r;
      dx3_r  <= {{psd_pkg::DW{dx_r[psd_pkg::DW-1]}}, dx_r};
      dy3_r  <= {{psd_pkg::DW{dy_r[psd_pkg::DW-1]}}, dy_r};
      dxx_r  <= dx_r * dx_r;
      dyy_r  <= dy_r * dy_r;
      exdx_r <= ex_r * dx_r;
      eydy_r <= ey_r * dy_r;
      // sums
      p4_r   <= p3_r;
      dx4_r  <= dx3_r[psd_pkg::DW-1:0];
      dy4_r  <= dy3_r[psd_pkg::DW-1:0];
      len2_r <= dxx_r[psd_pkg::L2W-1:0] + dyy_r[psd_pkg::L2W-1:0];
      dot_r  <= {exdx_r[2*psd_pkg::DW-1], exdx_r} + {eydy_r[2*psd_pkg::DW-1], eydy_r};
      // classified item
      job_r  <= job_nxt;
    end
  end

endmodule

[design/psd_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on psd_pkg
module psd_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [psd_pkg::NUMW-1:0]  num,
  input  logic [psd_pkg::L2W-1:0]   den,
  output logic [psd_pkg::QW-1:0]    quot
);

  logic [psd_pkg::L2W-1:0] rem_r [psd_pkg::QW];
  logic [psd_pkg::QW-1:0]  low_r [psd_pkg::QW];
  logic [psd_pkg::QW-1:0]  quo_r [psd_pkg::QW];
  logic [psd_pkg::L2W-1:0] den_r [psd_pkg::QW];

  logic [psd_pkg::L2W-1:0] rem_nxt [psd_pkg::QW];
  logic [psd_pkg::QW-1:0]  low_nxt [psd_pkg::QW];
  logic [psd_pkg::QW-1:0]  quo_nxt [psd_pkg::QW];
  logic [psd_pkg::L2W-1:0] den_nxt [psd_pkg::QW];

  logic [psd_pkg::L2W-1:0] rem_in  [psd_pkg::QW];
  logic [psd_pkg::QW-1:0]  low_in  [psd_pkg::QW];
  logic [psd_pkg::QW-1:0]  quo_in  [psd_pkg::QW];
  logic [psd_pkg::L2W:0]   trial   [psd_pkg::QW];
  logic [psd_pkg::L2W:0]   diff    [psd_pkg::QW];

  assign quot = quo_r[psd_pkg::QW-1];

  always_comb begin
    for (int k = 0; k < psd_pkg::QW; k++) begin
      if (k == 0) begin
        rem_in[k]  = num[psd_pkg::NUMW-1:psd_pkg::QW];
        low_in[k]  = num[psd_pkg::QW-1:0];
        quo_in[k]  = '0;
        den_nxt[k] = den;
      end else begin
        rem_in[k]  = rem_r[k-1];
        low_in[k]  = low_r[k-1];
        quo_in[k]  = quo_r[k-1];
        den_nxt[k] = den_r[k-1];
      end
      trial[k] = {rem_in[k], low_in[k][psd_pkg::QW-1]};
      diff[k]  = trial[k] - {1'b0, den_nxt[k]};
      if (trial[k] >= {1'b0, den_nxt[k]}) begin
        rem_nxt[k] = diff[k][psd_pkg::L2W-1:0];
        quo_nxt[k] = {quo_in[k][psd_pkg::QW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][psd_pkg::L2W-1:0];
        quo_nxt[k] = {quo_in[k][psd_pkg::QW-2:0], 1'b0};
      end
      low_nxt[k] = {low_in[k][psd_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < psd_pkg::QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_nxt[k];
      end
    end
  end

endmodule

[design/psd_sqrt.sv]
// pipelined digit by digit square root, one root bit per stage
// depends on psd_pkg
module psd_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [psd_pkg::SSW-1:0]   rad,
  output logic [psd_pkg::SRW-1:0]   root,
  output logic [psd_pkg::REMW-1:0]  rem
);

  logic [psd_pkg::REMW-1:0] rem_r  [psd_pkg::SRW];
  logic [psd_pkg::SRW-1:0]  root_r [psd_pkg::SRW];
  logic [psd_pkg::SSW-1:0]  rad_r  [psd_pkg::SRW];

  logic [psd_pkg::REMW-1:0] rem_nxt  [psd_pkg::SRW];
  logic [psd_pkg::SRW-1:0]  root_nxt [psd_pkg::SRW];
  logic [psd_pkg::SSW-1:0]  rad_nxt  [psd_pkg::SRW];

  logic [psd_pkg::REMW-1:0] rem_in  [psd_pkg::SRW];
  logic [psd_pkg::SRW-1:0]  root_in [psd_pkg::SRW];
  logic [psd_pkg::SSW-1:0]  rad_in  [psd_pkg::SRW];
  logic [psd_pkg::REMW+1:0] cur     [psd_pkg::SRW];
  logic [psd_pkg::REMW+1:0] trial   [psd_pkg::SRW];
  logic [psd_pkg::REMW+1:0] diff    [psd_pkg::SRW];

  assign root = root_r[psd_pkg::SRW-1];
  assign rem  = rem_r[psd_pkg::SRW-1];

  always_comb begin
    for (int k = 0; k < psd_pkg::SRW; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        rad_in[k]  = rad;
      end else begin
        rem_in[k]  = rem_r[k-1];
        root_in[k] = root_r[k-1];
        rad_in[k]  = rad_r[k-1];
      end
      cur[k]   = {rem_in[k], rad_in[k][psd_pkg::SSW-1:psd_pkg::SSW-2]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      diff[k]  = cur[k] - trial[k];
      if (cur[k] >= trial[k]) begin
        rem_nxt[k]  = diff[k][psd_pkg::REMW-1:0];
        root_nxt[k] = {root_in[k][psd_pkg::SRW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur[k][psd_pkg::REMW-1:0];
        root_nxt[k] = {root_in[k][psd_pkg::SRW-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_in[k][psd_pkg::SSW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < psd_pkg::SRW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
      end
    end
  end

endmodule

[design/psd_back.sv]
// back pipeline: interior projection, nearest point, distance and result queue
// depends on psd_pkg, psd_div and psd_sqrt
module psd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  psd_pkg::job_t                 job,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [psd_pkg::OW-1:0]        out_distance,
  output logic signed [psd_pkg::CW-1:0] out_nearest_x,
  output logic signed [psd_pkg::CW-1:0] out_nearest_y,
  output logic [1:0]                    out_region
);

  typedef struct packed {
    logic [1:0]             region;
    logic [psd_pkg::CW-1:0] a_x;
    logic [psd_pkg::CW-1:0] a_y;
    logic [psd_pkg::CW-1:0] b_x;
    logic [psd_pkg::CW-1:0] b_y;
    logic [psd_pkg::CW-1:0] c_x;
    logic [psd_pkg::CW-1:0] c_y;
    logic                   neg_x;
    logic                   neg_y;
  } geo_t;

  typedef struct packed {
    logic [1:0]             region;
    logic [psd_pkg::CW-1:0] p_x;
    logic [psd_pkg::CW-1:0] p_y;
  } pt_t;

  typedef struct packed {
    logic [psd_pkg::OW-1:0] distance;
    logic [psd_pkg::CW-1:0] nearest_x;
    logic [psd_pkg::CW-1:0] nearest_y;
    logic [1:0]             region;
  } res_t;

  logic [psd_pkg::BLAT-1:0] vld_r;
  logic                     en;
  logic                     last_vld;

  // stage registers
  geo_t                    g1_r, g2_r;
  geo_t                    dgeo_r [psd_pkg::QW];
  logic [psd_pkg::L2W-1:0] plo_x_r, phi_x_r, plo_y_r, phi_y_r, len2_1_r;
  logic [psd_pkg::NUMW-1:0] num_x_r, num_y_r;
  logic [psd_pkg::L2W-1:0] den_r;
  logic [psd_pkg::QW-1:0]  quo_x, quo_y;
  pt_t                     pt3_r, pt4_r, pt5_r, pt6_r;
  logic [psd_pkg::CW-1:0]  c3_x_r, c3_y_r;
  logic signed [psd_pkg::DW-1:0]   dd_x_r, dd_y_r;
  logic signed [2*psd_pkg::DW-1:0] sq_x_r, sq_y_r;
  logic [psd_pkg::SSW-1:0]         ss_r;
  pt_t                     dpt_r [psd_pkg::SRW];
  logic [psd_pkg::SRW-1:0]  root;
  logic [psd_pkg::REMW-1:0] rem;

  // combinational helpers
  logic [psd_pkg::MW-1:0]   mag_x, mag_y;
  logic [psd_pkg::L2W-1:0]  ext_mag_x, ext_mag_y, ext_lo, ext_hi;
  geo_t                     g3;
  logic [psd_pkg::DW-1:0]   off_x, off_y, sum_x, sum_y;
  pt_t                      pt3_nxt;
  logic [psd_pkg::SRW:0]    rnd;
  res_t                     res;

  // result queue
  res_t       ofifo_r [2];
  logic       owr_r;
  logic       ord_r;
  logic [1:0] ocnt_r;
  logic [1:0] ocnt_nxt;
  logic       ofull;
  logic       owrite;
  logic       oread;

  assign last_vld = vld_r[psd_pkg::BLAT-1];
  assign ofull    = (ocnt_r == 2'd2);
  assign en       = !(last_vld && ofull);
  assign q_pop    = en && !q_empty;
  assign owrite   = en && last_vld;
  assign empty    = (ocnt_r == 2'd0);
  assign oread    = pop && !empty;

  // projection products, dot split in two halves
  assign mag_x     = psd_pkg::mag(job.d_x);
  assign mag_y     = psd_pkg::mag(job.d_y);
  assign ext_mag_x = {{psd_pkg::MW{1'b0}}, mag_x};
  assign ext_mag_y = {{psd_pkg::MW{1'b0}}, mag_y};
  assign ext_lo    = {{psd_pkg::MW{1'b0}}, job.dot[psd_pkg::MW-1:0]};
  assign ext_hi    = {{psd_pkg::MW{1'b0}}, job.dot[psd_pkg::L2W-1:psd_pkg::MW]};

  psd_div u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (num_x_r),
    .den  (den_r),
    .quot (quo_x)
  );

  psd_div u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (num_y_r),
    .den  (den_r),
    .quot (quo_y)
  );

  // nearest point
  assign g3    = dgeo_r[psd_pkg::QW-1];
  assign off_x = g3.neg_x ? (~quo_x + 1'b1) : quo_x;
  assign off_y = g3.neg_y ? (~quo_y + 1'b1) : quo_y;
  assign sum_x = psd_pkg::sx(g3.a_x) + off_x;
  assign sum_y = psd_pkg::sx(g3.a_y) + off_y;

  always_comb begin
    pt3_nxt.region = g3.region;
    case (g3.region)
      psd_pkg::REGION_END: begin
        pt3_nxt.p_x = g3.b_x;
        pt3_nxt.p_y = g3.b_y;
      end
      psd_pkg::REGION_INSIDE: begin
        pt3_nxt.p_x = sum_x[psd_pkg::CW-1:0];
        pt3_nxt.p_y = sum_y[psd_pkg::CW-1:0];
      end
      default: begin
        pt3_nxt.p_x = g3.a_x;
        pt3_nxt.p_y = g3.a_y;
      end
    endcase
  end

  psd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (ss_r),
    .root (root),
    .rem  (rem)
  );

  // round half up, then saturate
  always_comb begin
    rnd = {1'b0, root};
    if (rem > {2'b00, root}) begin
      rnd = {1'b0, root} + 1'b1;
    end
    res.region    = dpt_r[psd_pkg::SRW-1].region;
    res.nearest_x = dpt_r[psd_pkg::SRW-1].p_x;
    res.nearest_y = dpt_r[psd_pkg::SRW-1].p_y;
    res.distance  = rnd[psd_pkg::SRW] ? {psd_pkg::OW{1'b1}} : rnd[psd_pkg::OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[psd_pkg::BLAT-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r.region <= job.region;
      g1_r.a_x    <= job.a_x;
      g1_r.a_y    <= job.a_y;
      g1_r.b_x    <= job.b_x;
      g1_r.b_y    <= job.b_y;
      g1_r.c_x    <= job.c_x;
      g1_r.c_y    <= job.c_y;
      g1_r.neg_x  <= job.d_x[psd_pkg::DW-1];
      g1_r.neg_y  <= job.d_y[psd_pkg::DW-1];
      plo_x_r     <= ext_lo * ext_mag_x;
      phi_x_r     <= ext_hi * ext_mag_x;
      plo_y_r     <= ext_lo * ext_mag_y;
      phi_y_r     <= ext_hi * ext_mag_y;
      len2_1_r    <= job.len2;
      // numerator with half the divisor added for rounding
      g2_r    <= g1_r;
      den_r   <= len2_1_r;
      num_x_r <= {phi_x_r, {psd_pkg::MW{1'b0}}} + {{psd_pkg::MW{1'b0}}, plo_x_r}
               + {{(psd_pkg::MW+1){1'b0}}, len2_1_r[psd_pkg::L2W-1:1]};
      num_y_r <= {phi_y_r, {psd_pkg::MW{1'b0}}} + {{psd_pkg::MW{1'b0}}, plo_y_r}
               + {{(psd_pkg::MW+1){1'b0}}, len2_1_r[psd_pkg::L2W-1:1]};
      // geometry follows the divider
      for (int k = 0; k < psd_pkg::QW; k++) begin
        dgeo_r[k] <= (k == 0) ? g2_r : dgeo_r[(k == 0) ? 0 : k-1];
      end
      pt3_r  <= pt3_nxt;
      c3_x_r <= g3.c_x;
      c3_y_r <= g3.c_y;
      // offset from nearest point to query
      pt4_r  <= pt3_r;
      dd_x_r <= psd_pkg::sx(c3_x_r) - psd_pkg::sx(pt3_r.p_x);
      dd_y_r <= psd_pkg::sx(c3_y_r) - psd_pkg::sx(pt3_r.p_y);
      pt5_r  <= pt4_r;
      sq_x_r <= dd_x_r * dd_x_r;
      sq_y_r <= dd_y_r * dd_y_r;
      pt6_r  <= pt5_r;
      ss_r   <= sq_x_r[psd_pkg::SSW-1:0] + sq_y_r[psd_pkg::SSW-1:0];
      // point follows the root
      for (int k = 0; k < psd_pkg::SRW; k++) begin
        dpt_r[k] <= (k == 0) ? pt6_r : dpt_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // two entry result queue
  assign out_distance  = ofifo_r[ord_r].distance;
  assign out_nearest_x = ofifo_r[ord_r].nearest_x;
  assign out_nearest_y = ofifo_r[ord_r].nearest_y;
  assign out_region    = ofifo_r[ord_r].region;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (owrite && !oread) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (oread && !owrite) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (owrite) begin
        owr_r <= !owr_r;
      end
      if (oread) begin
        ord_r <= !ord_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (owrite) begin
      ofifo_r[owr_r] <= res;
    end
  end

endmodule

[design/point_segment_distance.sv]
// top level of the point to segment distance block
// depends on psd_pkg, psd_front, psd_queue and psd_back
//
// usage
// - input side looks like a queue: drive the six coordinates and raise push;
//   the item is taken on a clock edge where push is high and full is low
// - result side looks like a queue: while empty is low the oldest result sits
//   on the out_ ports; raise pop to take it
// - each item gives exactly one result, in order: distance (rounded, saturated),
//   nearest point on the segment and the region code
// - throughput: one item per cycle sustained while pop keeps up; every item
//   takes the same path
// - from accept to empty going low an item passes the five front stages, the
//   middle queue, six fixed back stages, one divider stage per quotient bit
//   and one square root stage per root bit
// - if pop stays low the result queue fills, the back pipeline halts, the
//   middle queue fills and then full rises; nothing is dropped
// - synchronous reset empties every pipeline and queue; there is no other state
module point_segment_distance (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_x,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_y,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_x,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_y,
  input  logic signed [psd_pkg::CW-1:0] in_query_x,
  input  logic signed [psd_pkg::CW-1:0] in_query_y,
  output logic                          empty,
  input  logic                          pop,
  output logic [psd_pkg::OW-1:0]        out_distance,
  output logic signed [psd_pkg::CW-1:0] out_nearest_x,
  output logic signed [psd_pkg::CW-1:0] out_nearest_y,
  output logic [1:0]                    out_region
);

  // classified item leaving the front
  psd_pkg::job_t front_job;
  logic          front_vld;
  // middle queue status and head
  psd_pkg::job_t mid_job;
  logic          mid_full;
  logic          mid_empty;
  logic          mid_pop;

  // front: differences, squared length, dot product, region decision
  psd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_seg_start_x (in_seg_start_x),
    .in_seg_start_y (in_seg_start_y),
    .in_seg_end_x   (in_seg_end_x),
    .in_seg_end_y   (in_seg_end_y),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .q_full         (mid_full),
    .job_vld        (front_vld),
    .job            (front_job)
  );

  // short queue so front and back stall independently
  psd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (front_vld),
    .job_in  (front_job),
    .full    (mid_full),
    .pop     (mid_pop),
    .job_out (mid_job),
    .empty   (mid_empty)
  );

  // back: interior division, nearest point, square root, result queue
  psd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (mid_empty),
    .job           (mid_job),
    .q_pop         (mid_pop),
    .empty         (empty),
    .pop           (pop),
    .out_distance  (out_distance),
    .out_nearest_x (out_nearest_x),
    .out_nearest_y (out_nearest_y),
    .out_region    (out_region)
  );

endmodule

[verif/psd_checker.sv]
// checker for the point to segment distance block: watches both queue ports,
// predicts each result from the accepted item and compares in order
// depends on psd_pkg
`timescale 1ns / 100ps

module psd_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          full,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_x,
  input  logic signed [psd_pkg::CW-1:0] in_seg_start_y,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_x,
  input  logic signed [psd_pkg::CW-1:0] in_seg_end_y,
  input  logic signed [psd_pkg::CW-1:0] in_query_x,
  input  logic signed [psd_pkg::CW-1:0] in_query_y,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [psd_pkg::OW-1:0]        out_distance,
  input  logic signed [psd_pkg::CW-1:0] out_nearest_x,
  input  logic signed [psd_pkg::CW-1:0] out_nearest_y,
  input  logic [1:0]                    out_region,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic [psd_pkg::OW-1:0] distance;
    logic [psd_pkg::CW-1:0] nx;
    logic [psd_pkg::CW-1:0] ny;
    logic [1:0]             region;
  } nearest_t;

  nearest_t nearest_q[$];

  function automatic logic [63:0] root_rounded(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    if (n - r * r > r) r = r + 64'd1;
    return r;
  endfunction

  // offset along one axis, rounded half away from zero
  function automatic longint axis_offset(input longint dot, input longint d,
                                         input longint len2);
    logic [127:0] num;
    logic [127:0] q;
    longint m;
    m = (d < 0) ? -d : d;
    num = 128'(dot) * 128'(m) + 128'(len2 >> 1);
    q = num / 128'(len2);
    return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic nearest_t project(input longint ax, input longint ay,
                                       input longint bx, input longint by,
                                       input longint cx, input longint cy);
    nearest_t res;
    longint dx, dy, len2, dot, px, py, qx, qy;
    logic [63:0] sq, r;
    dx = bx - ax;
    dy = by - ay;
    len2 = dx * dx + dy * dy;
    dot = (cx - ax) * dx + (cy - ay) * dy;
    if (len2 == 0 || dot < 0) begin
      res.region = psd_pkg::REGION_START;
      px = ax;
      py = ay;
    end else if (dot > len2) begin
      res.region = psd_pkg::REGION_END;
      px = bx;
      py = by;
    end else begin
      res.region = psd_pkg::REGION_INSIDE;
      px = ax + axis_offset(dot, dx, len2);
      py = ay + axis_offset(dot, dy, len2);
    end
    qx = cx - px;
    qy = cy - py;
    sq = qx * qx + qy * qy;
    r = root_rounded(sq);
    res.distance = (r > 64'({psd_pkg::OW{1'b1}})) ? {psd_pkg::OW{1'b1}}
                                                  : r[psd_pkg::OW-1:0];
    res.nx = px[psd_pkg::CW-1:0];
    res.ny = py[psd_pkg::CW-1:0];
    return res;
  endfunction

  assign pending = nearest_q.size();

  always @(posedge clk) begin
    nearest_t want;
    if (!rst_n) begin
      nearest_q.delete();
      errors <= 0;
    end else begin
      if (pop && !empty) begin
        if (nearest_q.size() == 0) begin
          $display("%0t: result with none expected: dist %0d x %0d y %0d region %0d",
                   $time, out_distance, out_nearest_x, out_nearest_y, out_region);
          errors <= errors + 1;
        end else begin
          want = nearest_q.pop_front();
          if (want.distance !== out_distance || want.nx !== out_nearest_x ||
              want.ny !== out_nearest_y || want.region !== out_region) begin
            $display("%0t: mismatch expected dist %0d x %0d y %0d region %0d",
                     $time, want.distance, $signed(want.nx), $signed(want.ny),
                     want.region);
            $display("%0t:          actual   dist %0d x %0d y %0d region %0d",
                     $time, out_distance, out_nearest_x, out_nearest_y, out_region);
            errors <= errors + 1;
          end
        end
      end
      if (push && !full)
        nearest_q.insert(nearest_q.size(),
                         project(longint'(in_seg_start_x), longint'(in_seg_start_y),
                                 longint'(in_seg_end_x), longint'(in_seg_end_y),
                                 longint'(in_query_x), longint'(in_query_y)));
    end
  end

endmodule

[verif/testbench.sv]
// top of the point to segment distance testbench: clock, reset, stimulus
// and verdict; depends on psd_pkg, psd_checker and the block itself
`timescale 1ns / 100ps

module testbench;

  localparam int CMAX = (1 << (psd_pkg::CW - 1)) - 1;
  localparam int CMIN = -(1 << (psd_pkg::CW - 1));

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  logic signed [psd_pkg::CW-1:0] ax = '0, ay = '0, bx = '0, by = '0, qx = '0, qy = '0;
  logic [psd_pkg::OW-1:0] out_distance;
  logic signed [psd_pkg::CW-1:0] out_nearest_x, out_nearest_y;
  logic [1:0] out_region;
  int errors, pending;

  // idle rates in percent, changed per phase
  int send_idle = 30;
  int recv_idle = 80;
  bit hold_req = 0;

  always #5 clk = ~clk;

  point_segment_distance DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_seg_start_x(ax), .in_seg_start_y(ay),
    .in_seg_end_x(bx), .in_seg_end_y(by),
    .in_query_x(qx), .in_query_y(qy),
    .empty(empty), .pop(pop),
    .out_distance(out_distance), .out_nearest_x(out_nearest_x),
    .out_nearest_y(out_nearest_y), .out_region(out_region)
  );

  psd_checker u_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_seg_start_x(ax), .in_seg_start_y(ay),
    .in_seg_end_x(bx), .in_seg_end_y(by),
    .in_query_x(qx), .in_query_y(qy),
    .empty(empty), .pop(pop),
    .out_distance(out_distance), .out_nearest_x(out_nearest_x),
    .out_nearest_y(out_nearest_y), .out_region(out_region),
    .errors(errors), .pending(pending)
  );

  // offer one item, with a random gap first; returns at the accepting edge
  task automatic offer_segment(input int sx0, sy0, ex0, ey0, cx0, cy0);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    ax <= psd_pkg::CW'(sx0);
    ay <= psd_pkg::CW'(sy0);
    bx <= psd_pkg::CW'(ex0);
    by <= psd_pkg::CW'(ey0);
    qx <= psd_pkg::CW'(cx0);
    qy <= psd_pkg::CW'(cy0);
    // full is steady between edges, so the value at the falling edge decides
    do @(negedge clk); while (full);
    @(posedge clk);
  endtask

  // wait with the input quiet until every result has been taken
  task automatic drain_results();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic int rand_coord(input int span);
    if (span == 0) return int'($urandom_range(CMAX - CMIN)) + CMIN;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // receiver: random pops, with one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    int sx0, sy0, ex0, ey0, cx0, cy0;
    int span;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate segments, extremes of the range
    offer_segment(0, 0, 0, 0, 0, 0);
    offer_segment(100, -50, 100, -50, 356, 206);
    offer_segment(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX);  // largest distance, still below saturation
    offer_segment(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN);
    offer_segment(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX);
    offer_segment(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN);
    offer_segment(CMIN, 0, CMAX, 0, 0, CMAX);
    offer_segment(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN);
    offer_segment(-1, -1, 1, 1, -1, 1);
    // before the start, past the end, inside
    offer_segment(0, 0, 1024, 0, -300, 500);
    offer_segment(0, 0, 1024, 0, 2000, -500);
    offer_segment(0, 0, 1024, 0, 300, 700);
    // projection exactly on an endpoint counts as inside
    offer_segment(0, 0, 1024, 0, 0, 900);
    offer_segment(0, 0, 1024, 0, 1024, -900);
    // rounding of the offset, halves and negative directions
    offer_segment(0, 0, 3, 1, 1, 2);
    offer_segment(10, 10, 7, 9, 9, 8);
    offer_segment(-5, 7, 2, -4, 3, 3);
    offer_segment(0, 0, 2, 2, 1, 0);
    offer_segment(0, 0, -2, -2, -1, 0);
    offer_segment(1, 1, 1, 1, 2, 2);
    offer_segment(CMAX, CMAX, CMAX - 1, CMAX, CMIN, CMIN);

    for (int n = 0; n < 500; n++) begin
      // phase changes: swap idle rates, drain, long hold, then full speed
      if (n == 170) begin
        send_idle = 80;
        recv_idle = 30;
      end
      if (n == 250) drain_results();
      if (n == 340) begin
        send_idle = 0;
        recv_idle = 0;
        hold_req = 1;
      end
      case ($urandom_range(9))
        0, 1:    span = 0;        // full range
        2, 3, 4: span = 64;
        default: span = 4000;
      endcase
      sx0 = rand_coord(span);
      sy0 = rand_coord(span);
      ex0 = ($urandom_range(19) == 0) ? sx0 : rand_coord(span);
      ey0 = ($urandom_range(19) == 0) ? sy0 : rand_coord(span);
      cx0 = rand_coord(span);
      cy0 = rand_coord(span);
      offer_segment(sx0, sy0, ex0, ey0, cx0, cy0);
    end

    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
